// ----- hdl/wmmn_pkg.sv -----
package wmmn_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 15;
    localparam int MAX_WINDOW  = 128;
    localparam int AXES        = 3;
    localparam int LEN_BITS    = 8;
    localparam int NORM_BITS   = 16;

    localparam int QUOT_BITS   = FRAC_BITS + 1;
    localparam int DIFF_BITS   = SAMPLE_BITS;
    localparam int REM_BITS    = SAMPLE_BITS + 1;
    localparam int STEP_BITS   = $clog2(FRAC_BITS + 1);
    localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [NORM_BITS-1:0]          norm_t;
    typedef logic [LEN_BITS-1:0]           len_t;

    localparam len_t    WINDOW_RESET = len_t'(100);
    localparam sample_t SAMPLE_HIGH  = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam sample_t SAMPLE_LOW   = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_first;
        logic load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic window_done;
    } dp_status_t;

endpackage

// ----- hdl/wmmn_sample_if.sv -----
interface wmmn_sample_if;
    logic               valid;
    logic               ready;
    wmmn_pkg::sample_t  accel_x;
    wmmn_pkg::sample_t  accel_y;
    wmmn_pkg::sample_t  accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

// ----- hdl/wmmn_result_if.sv -----
interface wmmn_result_if;
    logic                           valid;
    logic                           ready;
    wmmn_pkg::norm_t                norm_x;
    wmmn_pkg::norm_t                norm_y;
    wmmn_pkg::norm_t                norm_z;
    logic [wmmn_pkg::AXES-1:0]      degenerate_mask;

    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    output degenerate_mask, input ready);
    modport sink   (input valid, input norm_x, input norm_y, input norm_z,
                    input degenerate_mask, output ready);
endinterface

// ----- hdl/wmmn_cfg_if.sv -----
interface wmmn_cfg_if;
    logic           valid;
    logic           ready;
    wmmn_pkg::len_t window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

// ----- hdl/windowed_minmax_normalizer.sv -----
// Windowed min/max normalizer for three-axis accelerometer samples. Each sample
// transfer folds the sample into a running per-axis minimum and maximum. The sample
// that closes a window of window_length samples (0 acts as 1, values above 128 act
// as 128) is emitted as (x - min) / (max - min) per axis in unsigned Q1.15,
// truncated, so 1.0 reads 32768; an axis whose max equals its min gives 0 and sets
// its bit in degenerate_mask (bit 0 x, bit 1 y, bit 2 z). Min, max and count then
// restart. Timing: a sample that does not close a window is taken while the block is idle, and the
// next may follow at once. A closing sample starts a radix-2 restoring divider,
// one quotient bit per cycle for all three axes side by side, so the block takes
// no new sample until its 16 divide steps and the handoff to the output register
// are done, plus any cycles the result register waits for the sink to
// take an earlier result. The result is held in a register, so it can wait on the
// sink while new samples of the next window are taken. Write window_length only
// while the block is idle.
module windowed_minmax_normalizer (
    input  logic                    clk,
    input  logic                    rst_n,
    wmmn_sample_if.sink             sample,
    wmmn_result_if.source           result,
    wmmn_cfg_if.sink                cfg
);

    wmmn_pkg::dp_cmd_t      cmd;
    wmmn_pkg::dp_status_t   status;
    logic                   in_ready;
    logic                   out_valid;

    // register writes are always taken
    assign cfg.ready    = 1'b1;
    assign sample.ready = in_ready;
    assign result.valid = out_valid;

    // sequencing: sample transfers, divide steps, result handoff
    wmmn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (result.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // window min/max, window count, per-axis divider lanes and result register
    wmmn_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .accel_x         (sample.accel_x),
        .accel_y         (sample.accel_y),
        .accel_z         (sample.accel_z),
        .cfg_write       (cfg.valid),
        .cfg_data        (cfg.window_length),
        .cmd             (cmd),
        .status          (status),
        .norm_x          (result.norm_x),
        .norm_y          (result.norm_y),
        .norm_z          (result.norm_z),
        .degenerate_mask (result.degenerate_mask)
    );

endmodule

// ----- hdl/wmmn_datapath.sv -----
module wmmn_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wmmn_pkg::sample_t           accel_x,
    input  wmmn_pkg::sample_t           accel_y,
    input  wmmn_pkg::sample_t           accel_z,
    input  logic                        cfg_write,
    input  wmmn_pkg::len_t              cfg_data,
    input  wmmn_pkg::dp_cmd_t           cmd,
    output wmmn_pkg::dp_status_t        status,
    output wmmn_pkg::norm_t             norm_x,
    output wmmn_pkg::norm_t             norm_y,
    output wmmn_pkg::norm_t             norm_z,
    output logic [wmmn_pkg::AXES-1:0]   degenerate_mask
);

    wmmn_pkg::sample_t                      samp       [wmmn_pkg::AXES];
    wmmn_pkg::sample_t                      max_reg    [wmmn_pkg::AXES];
    wmmn_pkg::sample_t                      min_reg    [wmmn_pkg::AXES];
    wmmn_pkg::sample_t                      max_new    [wmmn_pkg::AXES];
    wmmn_pkg::sample_t                      min_new    [wmmn_pkg::AXES];
    logic signed [wmmn_pkg::SAMPLE_BITS:0]  num_wide   [wmmn_pkg::AXES];
    logic signed [wmmn_pkg::SAMPLE_BITS:0]  den_wide   [wmmn_pkg::AXES];
    logic [wmmn_pkg::REM_BITS-1:0]          rem_reg    [wmmn_pkg::AXES];
    logic [wmmn_pkg::DIFF_BITS-1:0]         den_reg    [wmmn_pkg::AXES];
    logic [wmmn_pkg::QUOT_BITS-1:0]         quot_reg   [wmmn_pkg::AXES];
    logic [wmmn_pkg::REM_BITS-1:0]          trial      [wmmn_pkg::AXES];
    logic [wmmn_pkg::REM_BITS-1:0]          rem_next   [wmmn_pkg::AXES];
    logic [wmmn_pkg::QUOT_BITS-1:0]         quot_next  [wmmn_pkg::AXES];
    wmmn_pkg::norm_t                        norm_reg   [wmmn_pkg::AXES];
    logic [wmmn_pkg::AXES-1:0]              degen_reg;
    logic [wmmn_pkg::AXES-1:0]              degen_new;
    logic [wmmn_pkg::AXES-1:0]              mask_reg;
    logic [wmmn_pkg::COUNT_BITS-1:0]        count_reg;
    logic [wmmn_pkg::COUNT_BITS-1:0]        count_inc;
    logic [wmmn_pkg::COUNT_BITS-1:0]        eff_len;
    wmmn_pkg::len_t                         wl_reg;

    assign samp[0] = accel_x;
    assign samp[1] = accel_y;
    assign samp[2] = accel_z;

    // zero acts as one, oversize clamps to the window depth
    always_comb
    begin
        if (wl_reg == '0)
            eff_len = wmmn_pkg::COUNT_BITS'(1);
        else if (int'(wl_reg) > wmmn_pkg::MAX_WINDOW)
            eff_len = wmmn_pkg::COUNT_BITS'(wmmn_pkg::MAX_WINDOW);
        else
            eff_len = wmmn_pkg::COUNT_BITS'(wl_reg);
    end

    assign count_inc          = count_reg + 1'b1;
    assign status.window_done = (count_inc >= eff_len);

    // fold the incoming sample, form numerator and denominator
    always_comb
    begin
        for (int i = 0; i < wmmn_pkg::AXES; i++)
        begin
            max_new[i]   = (samp[i] > max_reg[i]) ? samp[i] : max_reg[i];
            min_new[i]   = (samp[i] < min_reg[i]) ? samp[i] : min_reg[i];
            num_wide[i]  = {samp[i][wmmn_pkg::SAMPLE_BITS-1], samp[i]}
                         - {min_new[i][wmmn_pkg::SAMPLE_BITS-1], min_new[i]};
            den_wide[i]  = {max_new[i][wmmn_pkg::SAMPLE_BITS-1], max_new[i]}
                         - {min_new[i][wmmn_pkg::SAMPLE_BITS-1], min_new[i]};
            degen_new[i] = (max_new[i] <= min_new[i]);
        end
    end

    // one restoring step per axis: first step compares unshifted
    always_comb
    begin
        for (int i = 0; i < wmmn_pkg::AXES; i++)
        begin
            trial[i] = cmd.div_first ? rem_reg[i] : {rem_reg[i][wmmn_pkg::REM_BITS-2:0], 1'b0};
            if (trial[i] >= {1'b0, den_reg[i]})
            begin
                rem_next[i]  = trial[i] - {1'b0, den_reg[i]};
                quot_next[i] = {quot_reg[i][wmmn_pkg::QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = trial[i];
                quot_next[i] = {quot_reg[i][wmmn_pkg::QUOT_BITS-2:0], 1'b0};
            end
        end
    end

    // window state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wmmn_pkg::AXES; i++)
            begin
                max_reg[i] <= wmmn_pkg::SAMPLE_LOW;
                min_reg[i] <= wmmn_pkg::SAMPLE_HIGH;
            end
            count_reg <= '0;
            wl_reg    <= wmmn_pkg::WINDOW_RESET;
        end
        else
        begin
            if (cfg_write)
                wl_reg <= cfg_data;
            if (cmd.accept)
            begin
                if (status.window_done)
                begin
                    for (int i = 0; i < wmmn_pkg::AXES; i++)
                    begin
                        max_reg[i] <= wmmn_pkg::SAMPLE_LOW;
                        min_reg[i] <= wmmn_pkg::SAMPLE_HIGH;
                    end
                    count_reg <= '0;
                end
                else
                begin
                    for (int i = 0; i < wmmn_pkg::AXES; i++)
                    begin
                        max_reg[i] <= max_new[i];
                        min_reg[i] <= min_new[i];
                    end
                    count_reg <= count_inc;
                end
            end
        end
    end

    // divider and output payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wmmn_pkg::AXES; i++)
        begin
            if (cmd.accept && status.window_done)
            begin
                rem_reg[i]  <= {1'b0, num_wide[i][wmmn_pkg::DIFF_BITS-1:0]};
                den_reg[i]  <= den_wide[i][wmmn_pkg::DIFF_BITS-1:0];
                quot_reg[i] <= '0;
            end
            else if (cmd.div_step)
            begin
                rem_reg[i]  <= rem_next[i];
                quot_reg[i] <= quot_next[i];
            end
            if (cmd.load_result)
                norm_reg[i] <= degen_reg[i] ? '0 : wmmn_pkg::NORM_BITS'(quot_reg[i]);
        end
        if (cmd.accept && status.window_done)
            degen_reg <= degen_new;
        if (cmd.load_result)
            mask_reg <= degen_reg;
    end

    assign norm_x          = norm_reg[0];
    assign norm_y          = norm_reg[1];
    assign norm_z          = norm_reg[2];
    assign degenerate_mask = mask_reg;

endmodule

// ----- hdl/wmmn_ctrl.sv -----
module wmmn_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  wmmn_pkg::dp_status_t    status,
    output wmmn_pkg::dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIVIDE,
        S_HOLD
    } state_t;

    state_t                         state_reg;
    logic [wmmn_pkg::STEP_BITS-1:0] step_reg;
    logic                           out_valid_reg;

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign cmd.accept      = in_valid && in_ready;
    assign cmd.div_step    = (state_reg == S_DIVIDE);
    assign cmd.div_first   = (step_reg == '0);
    assign cmd.load_result = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.accept && status.window_done)
                    begin
                        state_reg <= S_DIVIDE;
                        step_reg  <= '0;
                    end
                end
                S_DIVIDE:
                begin
                    if (step_reg == wmmn_pkg::STEP_BITS'(wmmn_pkg::FRAC_BITS))
                        state_reg <= S_HOLD;
                    else
                        step_reg <= step_reg + 1'b1;
                end
                S_HOLD:
                begin
                    if (cmd.load_result)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wmmn_pkg::*;

    // run bounds; a closing sample holds the block while it divides and hands off the result
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int SEGMENT_ITEMS = 130;
    localparam int NUM_SEGMENTS  = 9;

    typedef struct packed {
        sample_t x;
        sample_t y;
        sample_t z;
    } accel_sample_t;

    // norm[0] is x, norm[1] is y, norm[2] is z
    typedef struct packed {
        logic [AXES-1:0]       mask;
        norm_t [AXES-1:0]      norm;
    } norm_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // testbench-side copies of every block input, known from time zero
    logic    s_valid = 1'b0;
    sample_t s_x = '0;
    sample_t s_y = '0;
    sample_t s_z = '0;
    logic    r_ready = 1'b0;
    logic    c_valid = 1'b0;
    len_t    c_len = '0;

    wmmn_sample_if sample_bus ();
    wmmn_result_if result_bus ();
    wmmn_cfg_if    cfg_bus ();

    assign sample_bus.valid   = s_valid;
    assign sample_bus.accel_x = s_x;
    assign sample_bus.accel_y = s_y;
    assign sample_bus.accel_z = s_z;
    assign result_bus.ready   = r_ready;
    assign cfg_bus.valid      = c_valid;
    assign cfg_bus.window_length = c_len;

    windowed_minmax_normalizer DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // samples waiting to be offered, and normalized results waiting to arrive
    accel_sample_t pending_samples [$];
    norm_result_t  expected_norms [$];

    // shadow of the block's window state and its length register
    int   axis_hi [AXES];
    int   axis_lo [AXES];
    int   window_fill;
    len_t window_len_model;

    int   send_idle_pct = 16;
    int   recv_idle_pct = 47;
    bit   sample_fired = 1'b0;
    int   items_pushed = 0;
    int   samples_taken = 0;
    int   results_checked = 0;
    int   config_writes = 0;
    int   error_count = 0;
    int   cycle_count = 0;

    // restart min/max tracking for a new window
    function automatic void restart_window();
        int a;
        for (a = 0; a < AXES; a++)
        begin
            axis_hi[a] = int'(SAMPLE_LOW);
            axis_lo[a] = int'(SAMPLE_HIGH);
        end
        window_fill = 0;
    endfunction

    // fold one accepted sample into the window; on the closing sample,
    // queue the normalized result and restart the window
    function automatic void fold_sample(input sample_t sx, input sample_t sy,
                                        input sample_t sz);
        int               v [AXES];
        int               span;
        int               a;
        longint unsigned  num;
        longint unsigned  den;
        longint unsigned  quot;
        norm_result_t     res;
        v[0] = int'(sx);
        v[1] = int'(sy);
        v[2] = int'(sz);
        for (a = 0; a < AXES; a++)
        begin
            if (v[a] > axis_hi[a])
                axis_hi[a] = v[a];
            if (v[a] < axis_lo[a])
                axis_lo[a] = v[a];
        end
        window_fill++;
        // zero acts as one, anything above the maximum window is clamped
        span = int'(window_len_model);
        if (span == 0)
            span = 1;
        if (span > MAX_WINDOW)
            span = MAX_WINDOW;
        // a shortened length closes on the first sample at or past it
        if (window_fill >= span)
        begin
            res = '0;
            for (a = 0; a < AXES; a++)
            begin
                quot = 0;
                if (axis_hi[a] <= axis_lo[a])
                    res.mask[a] = 1'b1;   // flat axis reads zero
                else
                begin
                    num  = longint'(v[a] - axis_lo[a]);
                    den  = longint'(axis_hi[a] - axis_lo[a]);
                    quot = (num << FRAC_BITS) / den;
                end
                res.norm[a] = norm_t'(quot);
            end
            expected_norms.push_back(res);
            restart_window();
        end
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t mismatch on %s: expected %0d, got %0d",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    function automatic void queue_sample(input sample_t x, input sample_t y,
                                         input sample_t z);
        accel_sample_t item;
        item.x = x;
        item.y = y;
        item.z = z;
        pending_samples.push_back(item);
        items_pushed++;
    endfunction

    // full-range noise and samples near a base, some rail values
    function automatic sample_t random_axis(input sample_t base);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return SAMPLE_LOW;
        else if (pick < 16)
            return SAMPLE_HIGH;
        else if (pick < 55)
            return sample_t'(int'(base) + int'($urandom_range(128)) - 64);
        else
            return sample_t'($urandom_range(65535));
    endfunction

    // a run of random samples; some axes held flat for the whole run so
    // that windows with a degenerate axis come up
    task automatic queue_segment(input int count);
        sample_t held [AXES];
        sample_t base [AXES];
        bit      hold [AXES];
        sample_t v [AXES];
        int      n;
        int      a;
        for (a = 0; a < AXES; a++)
        begin
            held[a] = sample_t'($urandom_range(65535));
            base[a] = sample_t'($urandom_range(65535));
            hold[a] = ($urandom_range(4) == 0);
        end
        for (n = 0; n < count; n++)
        begin
            for (a = 0; a < AXES; a++)
                v[a] = hold[a] ? held[a] : random_axis(base[a]);
            queue_sample(v[0], v[1], v[2]);
        end
    endtask

    // wait until every queued sample is taken and every result has arrived
    task automatic drain_results();
        while (samples_taken != items_pushed || expected_norms.size() != 0)
            @(posedge clk);
    endtask

    // length register is only touched with the block idle
    task automatic write_window_length(input len_t value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        c_len   <= value;
        c_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge clk);
        c_valid <= 1'b0;
        config_writes++;
    endtask

    // driver: inputs change on the falling edge; a presented sample is held
    // until its transfer, then the next one may follow without a gap
    always @(negedge clk)
    begin : sample_driver
        accel_sample_t next_item;
        if (rst_n)
        begin
            if (!s_valid || sample_fired)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_samples.pop_front();
                    s_x     <= next_item.x;
                    s_y     <= next_item.y;
                    s_z     <= next_item.z;
                    s_valid <= 1'b1;
                end
                else
                    s_valid <= 1'b0;
            end
            // result sink stalls at random
            r_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: everything is sampled on the rising edge
    always @(posedge clk)
    begin : bus_monitor
        norm_result_t want;
        sample_fired = 1'b0;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
                window_len_model = cfg_bus.window_length;
            if (sample_bus.valid && sample_bus.ready)
            begin
                sample_fired = 1'b1;
                samples_taken++;
                fold_sample(sample_bus.accel_x, sample_bus.accel_y, sample_bus.accel_z);
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_norms.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, got %0d %0d %0d mask %0d",
                             $time, result_bus.norm_x, result_bus.norm_y,
                             result_bus.norm_z, result_bus.degenerate_mask);
                    error_count++;
                end
                else
                begin
                    want = expected_norms.pop_front();
                    check_field("norm_x", want.norm[0], result_bus.norm_x);
                    check_field("norm_y", want.norm[1], result_bus.norm_y);
                    check_field("norm_z", want.norm[2], result_bus.norm_z);
                    check_field("degenerate_mask", want.mask, result_bus.degenerate_mask);
                    results_checked++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[windowed_minmax_normalizer] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        len_t seg_len [NUM_SEGMENTS];
        int   seg;
        seg_len = '{8'd128, 8'd3, 8'd1, 8'd255, 8'd7, 8'd0, 8'd200, 8'd9, 8'd100};
        restart_window();
        window_len_model = WINDOW_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // partial window under the reset length, then a shorter length:
        // the kept count already passes it, so the next sample closes
        queue_sample(SAMPLE_LOW, SAMPLE_HIGH, 0);
        queue_sample(SAMPLE_HIGH, SAMPLE_LOW, 1);
        queue_sample(0, 0, -1);
        write_window_length(1);
        queue_sample(100, -100, 0);

        // single-sample windows: every axis flat
        queue_sample(SAMPLE_LOW, SAMPLE_LOW, SAMPLE_LOW);
        queue_sample(SAMPLE_HIGH, SAMPLE_HIGH, SAMPLE_HIGH);
        queue_sample(0, -1, 1);

        // zero length behaves as one
        write_window_length(0);
        queue_sample(1234, -1234, SAMPLE_HIGH);
        queue_sample(-1, 0, SAMPLE_LOW);

        // full-scale span: x lands on 1.0, y on 0, z flat
        write_window_length(2);
        queue_sample(SAMPLE_LOW, SAMPLE_HIGH, 5);
        queue_sample(SAMPLE_HIGH, SAMPLE_LOW, 5);
        queue_sample(SAMPLE_HIGH, SAMPLE_LOW, -7);
        queue_sample(SAMPLE_LOW, SAMPLE_HIGH, 7);

        // one flat axis, others inside the span
        write_window_length(3);
        queue_sample(10, 20, 30);
        queue_sample(10, 25, -30);
        queue_sample(10, 21, 0);

        // length shortened partway through a window
        write_window_length(5);
        queue_sample(-500, 700, 3);
        queue_sample(900, -700, 4);
        queue_sample(0, 0, 5);
        write_window_length(2);
        queue_sample(450, 350, 4);

        // random part: each segment sets a length, extremes among them,
        // then a run of samples; idling pattern changes every three segments
        for (seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            if (seg == 7)
                seg_len[seg] = len_t'($urandom_range(2, 16));
            write_window_length(seg_len[seg]);
            if (seg == 3)
            begin
                send_idle_pct = 47;
                recv_idle_pct = 16;
            end
            if (seg == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 1)
            begin
                // sender holds off until every pending result is back
                queue_segment(SEGMENT_ITEMS / 2);
                drain_results();
                queue_segment(SEGMENT_ITEMS - SEGMENT_ITEMS / 2);
            end
            else
                queue_segment(SEGMENT_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d accelerometer samples and %0d normalized results",
                 samples_taken, results_checked);
        $display("window length set %0d times, from 0 up through 255, under three stall patterns",
                 config_writes);
        if (error_count == 0 && expected_norms.size() == 0)
            $display("[windowed_minmax_normalizer] OK");
        else
            $display("[windowed_minmax_normalizer] ERROR");
        $finish;
    end

endmodule
